/* rtl/pal_pkg.sv */
// ----------------------------------------------------------------------------
// pal_pkg
// Shared sizes, command and status codes, and cell control for the list.
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int CAPACITY   = 16;
	localparam int ELEM_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = 5;
	localparam int POS_W      = 5;
	localparam int CMD_W      = 3;
	localparam int STATUS_W   = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT   = 3'd0,
		CMD_REMOVE   = 3'd1,
		CMD_GET      = 3'd2,
		CMD_INDEX_OF = 3'd3,
		CMD_FIRST    = 3'd4,
		CMD_LAST     = 3'd5,
		CMD_CLEAR    = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_BAD_POS   = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SEL_HOLD  = 2'd0,
		SEL_LOAD  = 2'd1,
		SEL_LEFT  = 2'd2,
		SEL_RIGHT = 2'd3
	} cell_sel_t;

	typedef struct packed {
		logic      en;
		cell_sel_t sel;
	} cell_ctl_t;

endpackage

/* rtl/pal_cmd_if.sv */
// ----------------------------------------------------------------------------
// pal_cmd_if
// Command channel: valid, ready and one command word.
// ----------------------------------------------------------------------------
interface pal_cmd_if;
	import pal_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic [POS_W-1:0]      position;
	logic [ELEM_WIDTH-1:0] value;

	modport source (output valid, output cmd, output position, output value, input ready);
	modport sink   (input valid, input cmd, input position, input value, output ready);

endinterface

/* rtl/pal_rsp_if.sv */
// ----------------------------------------------------------------------------
// pal_rsp_if
// Response channel: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface pal_rsp_if;
	import pal_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [ELEM_WIDTH-1:0] read_value;
	logic [IDX_W-1:0]      found_index;
	logic [CNT_W-1:0]      count_now;

	modport source (output valid, output status, output read_value, output found_index,
		output count_now, input ready);
	modport sink   (input valid, input status, input read_value, input found_index,
		input count_now, output ready);

endinterface

/* rtl/pal_cell.sv */
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds, loads, or takes its neighbour's entry; flags a match.
// ----------------------------------------------------------------------------
module pal_cell
	import pal_pkg::*;
(
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [ELEM_WIDTH-1:0] left_data,
	input  logic [ELEM_WIDTH-1:0] right_data,
	input  logic [ELEM_WIDTH-1:0] load_data,
	input  logic [ELEM_WIDTH-1:0] key,
	output logic [ELEM_WIDTH-1:0] data,
	output logic                  match
);

	logic [ELEM_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			unique case (ctl.sel)
				SEL_HOLD:  data_q <= data_q;
				SEL_LOAD:  data_q <= load_data;
				SEL_LEFT:  data_q <= left_data;
				SEL_RIGHT: data_q <= right_data;
				default:   data_q <= data_q;
			endcase
		end
	end

	assign data  = data_q;
	assign match = (data_q == key);

endmodule

/* rtl/positional_array_list.sv */
// ----------------------------------------------------------------------------
// positional_array_list: ordered list over a row of shifting cells.
// One word per cycle unless a held result is not taken; result is registered.
// The cell row shifts, loads and compares all slots in the accepting cycle.
// Reset empties the list and clears the result valid; slot contents are kept.
// ----------------------------------------------------------------------------
module positional_array_list
	import pal_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	pal_cmd_if.sink   req,
	pal_rsp_if.source rsp
);

	logic [CNT_W-1:0]      cnt_q;
	logic                  rsp_valid_q;
	status_t               status_q;
	logic [ELEM_WIDTH-1:0] read_value_q;
	logic [IDX_W-1:0]      found_index_q;
	logic [CNT_W-1:0]      count_now_q;

	logic                  fire;
	cmd_t                  cmd;
	logic                  full;
	logic                  empty;
	logic                  ins_ok;
	logic                  rem_ok;
	logic [IDX_W-1:0]      rd_addr;
	logic [ELEM_WIDTH-1:0] rd_data;
	logic                  any_hit;
	logic [IDX_W-1:0]      hit_idx;
	status_t               status_d;
	logic [ELEM_WIDTH-1:0] read_value_d;
	logic [IDX_W-1:0]      found_index_d;
	logic [CNT_W-1:0]      cnt_d;

	logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]   cell_match;
	cell_ctl_t             cell_ctl  [CAPACITY];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign cmd       = cmd_t'(req.cmd);
	assign full      = (cnt_q == CNT_W'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign ins_ok    = !full && (req.position <= cnt_q);
	assign rem_ok    = !empty && (req.position < cnt_q);

	always_comb begin
		if (cmd == CMD_FIRST)
			rd_addr = '0;
		else if (cmd == CMD_LAST)
			rd_addr = IDX_W'(cnt_q - CNT_W'(1));
		else
			rd_addr = req.position[IDX_W-1:0];
	end

	assign rd_data = cell_data[rd_addr];

	always_comb begin
		any_hit = 1'b0;
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_match[i] && (CNT_W'(i) < cnt_q)) begin
				any_hit = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		status_d      = ST_OK;
		read_value_d  = '0;
		found_index_d = '0;
		cnt_d         = cnt_q;
		unique case (cmd)
			CMD_INSERT: begin
				if (full)
					status_d = ST_FULL;
				else if (!ins_ok)
					status_d = ST_BAD_POS;
				else
					cnt_d = cnt_q + CNT_W'(1);
			end
			CMD_REMOVE, CMD_GET: begin
				if (empty)
					status_d = ST_EMPTY;
				else if (!rem_ok)
					status_d = ST_BAD_POS;
				else begin
					read_value_d = rd_data;
					if (cmd == CMD_REMOVE)
						cnt_d = cnt_q - CNT_W'(1);
				end
			end
			CMD_INDEX_OF: begin
				if (empty)
					status_d = ST_EMPTY;
				else if (!any_hit)
					status_d = ST_NOT_FOUND;
				else
					found_index_d = hit_idx;
			end
			CMD_FIRST, CMD_LAST: begin
				if (empty)
					status_d = ST_EMPTY;
				else
					read_value_d = rd_data;
			end
			CMD_CLEAR: cnt_d = '0;
			default: ;
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [ELEM_WIDTH-1:0] left_data;
		logic [ELEM_WIDTH-1:0] right_data;

		if (g == 0) begin : g_first
			assign left_data = req.value;
		end else begin : g_mid_l
			assign left_data = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_data = cell_data[g];
		end else begin : g_mid_r
			assign right_data = cell_data[g+1];
		end

		always_comb begin
			cell_ctl[g].en  = 1'b0;
			cell_ctl[g].sel = SEL_HOLD;
			if (fire && cmd == CMD_INSERT && ins_ok) begin
				if (CNT_W'(g) == req.position) begin
					cell_ctl[g].en  = 1'b1;
					cell_ctl[g].sel = SEL_LOAD;
				end else if (CNT_W'(g) > req.position) begin
					cell_ctl[g].en  = 1'b1;
					cell_ctl[g].sel = SEL_LEFT;
				end
			end else if (fire && cmd == CMD_REMOVE && rem_ok) begin
				if (CNT_W'(g) >= req.position) begin
					cell_ctl[g].en  = 1'b1;
					cell_ctl[g].sel = SEL_RIGHT;
				end
			end
		end

		pal_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[g]),
			.left_data  (left_data),
			.right_data (right_data),
			.load_data  (req.value),
			.key        (req.value),
			.data       (cell_data[g]),
			.match      (cell_match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				cnt_q       <= cnt_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= status_d;
			read_value_q  <= read_value_d;
			found_index_q <= found_index_d;
			count_now_q   <= cnt_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.found_index = found_index_q;
	assign rsp.count_now   = count_now_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd == CMD_INSERT && ins_ok |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_rsp_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q && count_now_q == cnt_q)
		else $error("reported count differs from held count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q != ST_OK |-> read_value_q == '0 && found_index_q == '0)
		else $error("error word carries data");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: positional_array_list testbench
// Drives list commands over the command channel and checks every result
// against table words or a shadow list kept in the testbench. A short directed
// table covers empty, full, bad-position, not-found and the unused command,
// then random traffic runs under varying idle rates and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
	import pal_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	typedef struct packed {
		status_t               status;
		logic [ELEM_WIDTH-1:0] read_value;
		logic [IDX_W-1:0]      found_index;
		logic [CNT_W-1:0]      count_now;
	} list_result_t;

	typedef struct {
		logic [CMD_W-1:0]      cmd;
		logic [POS_W-1:0]      pos;
		logic [ELEM_WIDTH-1:0] val;
		int                    reps;
		bit                    typed;
		list_result_t          want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	pal_cmd_if cmd_ch ();
	pal_rsp_if rsp_ch ();

	positional_array_list u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd_ch),
		.rsp    (rsp_ch)
	);

	logic [ELEM_WIDTH-1:0] shadow_slots [CAPACITY];
	int                    shadow_count;
	logic [ELEM_WIDTH-1:0] value_pool [8];
	list_result_t          pending_results [$];
	plan_row_t             plan [$];
	int                    fail_count;
	int                    src_idle_pct;
	int                    snk_idle_pct;
	bit                    stall_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic list_result_t list_apply(input logic [CMD_W-1:0] cmd,
		input logic [POS_W-1:0] pos, input logic [ELEM_WIDTH-1:0] val);
		list_result_t r;
		int i;
		r.status      = ST_OK;
		r.read_value  = '0;
		r.found_index = '0;
		case (cmd)
			CMD_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (pos > shadow_count) begin
					r.status = ST_BAD_POS;
				end else begin
					for (i = shadow_count; i > pos; i--)
						shadow_slots[i] = shadow_slots[i-1];
					shadow_slots[pos] = val;
					shadow_count++;
				end
			end
			CMD_REMOVE, CMD_GET: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else if (pos >= shadow_count) begin
					r.status = ST_BAD_POS;
				end else begin
					r.read_value = shadow_slots[pos];
					if (cmd == CMD_REMOVE) begin
						for (i = pos; i + 1 < shadow_count; i++)
							shadow_slots[i] = shadow_slots[i+1];
						shadow_count--;
					end
				end
			end
			CMD_INDEX_OF: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.status = ST_NOT_FOUND;
					// scan downwards so the lowest match wins
					for (i = shadow_count - 1; i >= 0; i--) begin
						if (shadow_slots[i] == val) begin
							r.status      = ST_OK;
							r.found_index = IDX_W'(i);
						end
					end
				end
			end
			CMD_FIRST, CMD_LAST: begin
				if (shadow_count == 0)
					r.status = ST_EMPTY;
				else if (cmd == CMD_FIRST)
					r.read_value = shadow_slots[0];
				else
					r.read_value = shadow_slots[shadow_count-1];
			end
			CMD_CLEAR: begin
				shadow_count = 0;
			end
			default: ;
		endcase
		r.count_now = CNT_W'(shadow_count);
		return r;
	endfunction

	function automatic void add_row(input logic [CMD_W-1:0] cmd, input int pos,
		input logic [ELEM_WIDTH-1:0] val, input int reps, input bit typed,
		input status_t st, input logic [ELEM_WIDTH-1:0] rd, input int idx, input int cnt);
		plan_row_t row;
		row.cmd                = cmd;
		row.pos                = POS_W'(pos);
		row.val                = val;
		row.reps               = reps;
		row.typed              = typed;
		row.want.status        = st;
		row.want.read_value    = rd;
		row.want.found_index   = IDX_W'(idx);
		row.want.count_now     = CNT_W'(cnt);
		plan.push_back(row);
	endfunction

	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
		input logic [ELEM_WIDTH-1:0] val, output list_result_t pred);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.cmd      <= cmd;
		cmd_ch.position <= pos;
		cmd_ch.value    <= val;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		pred = list_apply(cmd, pos, val);
	endtask

	task automatic wait_for_results();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int n);
		int r;
		int ins_w;
		int rem_w;
		int cnt;
		logic [CMD_W-1:0] c;
		logic [POS_W-1:0] p;
		logic [ELEM_WIDTH-1:0] v;
		list_result_t pred;
		for (int j = 0; j < n; j++) begin
			cnt   = shadow_count;
			ins_w = (cnt <= 4) ? 55 : (cnt <= 12 ? 35 : 25);
			rem_w = (cnt <= 4) ? 10 : (cnt <= 12 ? 25 : 35);
			r     = $urandom_range(0, 99);
			if (r < 2)
				c = CMD_CLEAR;
			else if (r < 4)
				c = CMD_UNUSED;
			else if (r < 4 + ins_w)
				c = CMD_INSERT;
			else if (r < 4 + ins_w + rem_w)
				c = CMD_REMOVE;
			else
				c = CMD_W'($urandom_range(CMD_GET, CMD_LAST));

			if ($urandom_range(0, 99) < 85 && cnt > 0)
				p = POS_W'($urandom_range(0, (c == CMD_INSERT) ? cnt : cnt - 1));
			else
				p = POS_W'($urandom_range(0, 31));

			r = $urandom_range(0, 99);
			if (c == CMD_INDEX_OF && cnt > 0 && r < 60)
				v = shadow_slots[$urandom_range(0, cnt - 1)];
			else if ((c == CMD_INSERT || c == CMD_INDEX_OF) && r < 80)
				v = value_pool[$urandom_range(0, 7)];
			else
				v = $urandom;

			send_word(c, p, v, pred);
			pending_results.push_back(pred);
		end
	endtask

	task automatic check_field(input string name, input logic [ELEM_WIDTH-1:0] want,
		input logic [ELEM_WIDTH-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing pending, status %0d", $time,
					rsp_ch.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", ELEM_WIDTH'(want.status), ELEM_WIDTH'(rsp_ch.status));
				check_field("read_value", want.read_value, rsp_ch.read_value);
				check_field("found_index", ELEM_WIDTH'(want.found_index),
					ELEM_WIDTH'(rsp_ch.found_index));
				check_field("count_now", ELEM_WIDTH'(want.count_now),
					ELEM_WIDTH'(rsp_ch.count_now));
			end
		end
	end

	initial begin
		int stall_left;
		rsp_ch.ready = 1'b0;
		stall_left   = 0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_left = 60;
				stall_req  = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	initial begin
		list_result_t pred;
		int guard;
		arst_n          = 1'b0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.cmd      = '0;
		cmd_ch.position = '0;
		cmd_ch.value    = '0;
		shadow_count    = 0;
		fail_count      = 0;
		stall_req       = 1'b0;
		src_idle_pct    = 25;
		snk_idle_pct    = 49;
		value_pool[0]   = '0;
		value_pool[1]   = '1;
		for (int i = 2; i < 8; i++)
			value_pool[i] = $urandom;

		add_row(CMD_GET,      0,  32'h0,         1,  1, ST_EMPTY,     32'h0,         0, 0);
		add_row(CMD_REMOVE,   0,  32'h0,         1,  1, ST_EMPTY,     32'h0,         0, 0);
		add_row(CMD_FIRST,    0,  32'h0,         1,  1, ST_EMPTY,     32'h0,         0, 0);
		add_row(CMD_LAST,     0,  32'h0,         1,  1, ST_EMPTY,     32'h0,         0, 0);
		add_row(CMD_INDEX_OF, 0,  32'h0,         1,  1, ST_EMPTY,     32'h0,         0, 0);
		add_row(CMD_INSERT,   1,  32'h1,         1,  1, ST_BAD_POS,   32'h0,         0, 0);
		add_row(CMD_INSERT,   0,  32'h0,         1,  1, ST_OK,        32'h0,         0, 1);
		add_row(CMD_INSERT,   1,  32'hFFFF_FFFF, 1,  1, ST_OK,        32'h0,         0, 2);
		add_row(CMD_INSERT,   31, 32'h5,         1,  1, ST_BAD_POS,   32'h0,         0, 2);
		add_row(CMD_GET,      0,  32'h0,         1,  1, ST_OK,        32'h0,         0, 2);
		add_row(CMD_GET,      1,  32'h0,         1,  1, ST_OK,        32'hFFFF_FFFF, 0, 2);
		add_row(CMD_GET,      2,  32'h0,         1,  1, ST_BAD_POS,   32'h0,         0, 2);
		add_row(CMD_REMOVE,   31, 32'h0,         1,  1, ST_BAD_POS,   32'h0,         0, 2);
		add_row(CMD_INDEX_OF, 0,  32'hFFFF_FFFF, 1,  1, ST_OK,        32'h0,         1, 2);
		add_row(CMD_INDEX_OF, 0,  32'h5,         1,  1, ST_NOT_FOUND, 32'h0,         0, 2);
		add_row(CMD_FIRST,    0,  32'h0,         1,  1, ST_OK,        32'h0,         0, 2);
		add_row(CMD_LAST,     0,  32'h0,         1,  1, ST_OK,        32'hFFFF_FFFF, 0, 2);
		add_row(CMD_UNUSED,   31, 32'hFFFF_FFFF, 1,  1, ST_OK,        32'h0,         0, 2);
		add_row(CMD_INSERT,   1,  32'hA5A5_5A5A, 1,  0, ST_OK,        32'h0,         0, 0);
		add_row(CMD_REMOVE,   0,  32'h0,         1,  0, ST_OK,        32'h0,         0, 0);
		add_row(CMD_INSERT,   0,  32'h1000,      14, 0, ST_OK,        32'h0,         0, 0);
		add_row(CMD_INSERT,   0,  32'h7,         1,  1, ST_FULL,      32'h0,         0, 16);
		add_row(CMD_INSERT,   31, 32'h7,         1,  1, ST_FULL,      32'h0,         0, 16);
		add_row(CMD_INDEX_OF, 0,  32'h1000,      1,  0, ST_OK,        32'h0,         0, 0);
		add_row(CMD_LAST,     0,  32'h0,         1,  0, ST_OK,        32'h0,         0, 0);
		add_row(CMD_REMOVE,   15, 32'h0,         1,  0, ST_OK,        32'h0,         0, 0);
		add_row(CMD_INSERT,   15, 32'hDEAD_BEEF, 1,  0, ST_OK,        32'h0,         0, 0);
		add_row(CMD_CLEAR,    0,  32'h0,         1,  1, ST_OK,        32'h0,         0, 0);
		add_row(CMD_GET,      0,  32'h0,         1,  1, ST_EMPTY,     32'h0,         0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < plan.size(); n++) begin
			for (int k = 0; k < plan[n].reps; k++) begin
				send_word(plan[n].cmd, plan[n].pos, plan[n].val + k, pred);
				if (plan[n].typed)
					pending_results.push_back(plan[n].want);
				else
					pending_results.push_back(pred);
			end
		end
		wait_for_results();

		run_random(230);
		wait_for_results();

		src_idle_pct = 49;
		snk_idle_pct = 25;
		run_random(230);
		wait_for_results();

		// hold the receiver off while words keep coming
		src_idle_pct = 0;
		snk_idle_pct = 0;
		stall_req    = 1'b1;
		run_random(24);
		wait_for_results();
		run_random(230);
		cmd_ch.valid <= 1'b0;

		guard = 0;
		while (pending_results.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			fail_count++;
		end
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
